### design/gsss_pkg.sv
// Shared types and constants for the generator start/stop sequencer.
package gsss_pkg;

    localparam int unsigned TimeW    = 32;
    localparam int unsigned DurW     = 16;
    localparam int unsigned StatusW  = 3;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned InDataW  = 40;
    localparam int unsigned OutDataW = 8;

    localparam logic [CfgIdxW-1:0] CFG_STARTUP_HOLD  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_CRANK         = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_SHUTDOWN_HOLD = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_COOLDOWN      = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_BLINK_PERIOD  = 3'd4;

    localparam logic [DurW-1:0] RST_STARTUP_HOLD  = 16'd1000;
    localparam logic [DurW-1:0] RST_CRANK         = 16'd3000;
    localparam logic [DurW-1:0] RST_SHUTDOWN_HOLD = 16'd1000;
    localparam logic [DurW-1:0] RST_COOLDOWN      = 16'd3000;
    localparam logic [DurW-1:0] RST_BLINK_PERIOD  = 16'd200;

    localparam logic [StatusW-1:0] ST_IDLE     = 3'd0;
    localparam logic [StatusW-1:0] ST_STARTUP  = 3'd1;
    localparam logic [StatusW-1:0] ST_CRANK    = 3'd2;
    localparam logic [StatusW-1:0] ST_RUNNING  = 3'd3;
    localparam logic [StatusW-1:0] ST_SHUTDOWN = 3'd4;
    localparam logic [StatusW-1:0] ST_COOLDOWN = 3'd5;
    localparam logic [StatusW-1:0] ST_STOPPED  = 3'd6;

    typedef struct packed {
        logic [DurW-1:0] startup_hold_ms;
        logic [DurW-1:0] crank_ms;
        logic [DurW-1:0] shutdown_hold_ms;
        logic [DurW-1:0] cooldown_ms;
        logic [DurW-1:0] blink_period_ms;
    } t_cfg;

    // packed so that lamp_one lands in bit 0
    typedef struct packed {
        logic               is_running;
        logic [StatusW-1:0] status_code;
        logic               lamp_three;
        logic               lamp_two;
        logic               lamp_one;
    } t_result;

endpackage

### design/generator_start_stop_sequencer.sv
// Top level of the generator start/stop sequencer: stream ports, input and result registers.
//
// Each input transfer is one update call (timestamp and run request) and yields exactly one
// result transfer (three lamp levels, status code, running flag). The block takes one transfer
// per clock while the result side keeps accepting; each item passes the input register and then
// the result register, with the combinational phase logic between them. A held result stalls the
// input side only once both registers are full. Durations are written through the plain register
// port and must only change while no update is in flight.
module generator_start_stop_sequencer import gsss_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,   // [31:0] time_ms, [32] request_run, rest zero
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata,   // [0] lamp_one, [1] lamp_two, [2] lamp_three,
                                                // [5:3] status_code, [6] is_running, [7] zero
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [DurW-1:0]     i_cfg_data
);

    logic             r_in_valid;
    logic [TimeW-1:0] r_in_time;
    logic             r_in_req;
    logic             r_out_valid;
    t_result          r_out;

    t_cfg    cfg;
    t_result res;
    logic    advance;
    logic    in_xfer;

    // item moves from input register to result register
    assign advance = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    gsss_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    gsss_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (advance),
        .i_time  (r_in_time),
        .i_req   (r_in_req),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_time <= s_axis_tdata[TimeW-1:0];
            r_in_req  <= s_axis_tdata[TimeW];
        end
        if (advance) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out};

    a_no_result_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_out))
        else $error("pending result overwritten");

    a_running_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.is_running == (r_out.status_code == ST_RUNNING))
        else $error("running flag disagrees with status");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_time) && $stable(r_in_req))
        else $error("queued update lost");

endmodule

### design/gsss_cfg.sv
// Configuration register bank for the sequencer durations.
module gsss_cfg import gsss_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [DurW-1:0]    i_cfg_data,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.startup_hold_ms  <= RST_STARTUP_HOLD;
            r_cfg.crank_ms         <= RST_CRANK;
            r_cfg.shutdown_hold_ms <= RST_SHUTDOWN_HOLD;
            r_cfg.cooldown_ms      <= RST_COOLDOWN;
            r_cfg.blink_period_ms  <= RST_BLINK_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STARTUP_HOLD:  r_cfg.startup_hold_ms  <= i_cfg_data;
                CFG_CRANK:         r_cfg.crank_ms         <= i_cfg_data;
                CFG_SHUTDOWN_HOLD: r_cfg.shutdown_hold_ms <= i_cfg_data;
                CFG_COOLDOWN:      r_cfg.cooldown_ms      <= i_cfg_data;
                CFG_BLINK_PERIOD:  r_cfg.blink_period_ms  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/gsss_core.sv
// Phase state machine, phase and blink timers, lamp and status decode.
module gsss_core import gsss_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_upd,
    input  logic [TimeW-1:0] i_time,
    input  logic             i_req,
    input  t_cfg             i_cfg,
    output t_result          o_res
);

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_STARTUP  = 3'd1,
        PH_CRANK    = 3'd2,
        PH_RUNNING  = 3'd3,
        PH_SHUTDOWN = 3'd4,
        PH_COOLDOWN = 3'd5,
        PH_STOPPED  = 3'd6
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [TimeW-1:0] r_start, n_start;
    logic [TimeW-1:0] r_toggle, n_toggle;
    logic             r_blink, n_blink;

    logic [TimeW-1:0] phase_elapsed;
    logic [TimeW-1:0] toggle_elapsed;
    logic             toggle_due;
    logic             blink_next;
    logic [TimeW-1:0] toggle_next;
    logic             l1, l2, l3;
    logic [StatusW-1:0] status;

    // modulo 2^32 elapsed times
    assign phase_elapsed  = i_time - r_start;
    assign toggle_elapsed = i_time - r_toggle;
    assign toggle_due     = toggle_elapsed >= {{(TimeW-DurW){1'b0}}, i_cfg.blink_period_ms};
    assign blink_next     = r_blink ^ toggle_due;
    assign toggle_next    = toggle_due ? i_time : r_toggle;

    always_comb begin
        n_phase  = r_phase;
        n_start  = r_start;
        n_toggle = r_toggle;
        n_blink  = r_blink;
        l1       = 1'b0;
        l2       = 1'b0;
        l3       = 1'b0;
        status   = ST_IDLE;
        unique case (r_phase)
            PH_IDLE, PH_STOPPED: begin
                status = (r_phase == PH_IDLE) ? ST_IDLE : ST_STOPPED;
                if (i_req) begin
                    l1      = 1'b1;
                    status  = ST_STARTUP;
                    n_start = i_time;
                    n_phase = PH_STARTUP;
                end
            end
            PH_STARTUP: begin
                if (!i_req) begin
                    status  = ST_STOPPED;
                    n_phase = PH_STOPPED;
                end else begin
                    l1     = 1'b1;
                    status = ST_STARTUP;
                    if (phase_elapsed >= {{(TimeW-DurW){1'b0}}, i_cfg.startup_hold_ms}) begin
                        n_blink  = 1'b0;
                        n_toggle = i_time;
                        n_start  = i_time;
                        status   = ST_CRANK;
                        n_phase  = PH_CRANK;
                    end
                end
            end
            PH_CRANK: begin
                if (!i_req) begin
                    status  = ST_STOPPED;
                    n_phase = PH_STOPPED;
                end else begin
                    n_blink  = blink_next;
                    n_toggle = toggle_next;
                    l1       = 1'b1;
                    l2       = blink_next;
                    status   = ST_CRANK;
                    if (phase_elapsed >= {{(TimeW-DurW){1'b0}}, i_cfg.crank_ms}) begin
                        l1      = 1'b0;
                        l2      = 1'b0;
                        l3      = 1'b1;
                        status  = ST_RUNNING;
                        n_start = i_time;
                        n_phase = PH_RUNNING;
                    end
                end
            end
            PH_RUNNING: begin
                l3     = 1'b1;
                status = ST_RUNNING;
                if (!i_req) begin
                    l1      = 1'b1;
                    status  = ST_SHUTDOWN;
                    n_start = i_time;
                    n_phase = PH_SHUTDOWN;
                end
            end
            PH_SHUTDOWN: begin
                l3 = 1'b1;
                if (i_req) begin
                    status  = ST_RUNNING;
                    n_phase = PH_RUNNING;
                end else begin
                    l1     = 1'b1;
                    status = ST_SHUTDOWN;
                    if (phase_elapsed >= {{(TimeW-DurW){1'b0}}, i_cfg.shutdown_hold_ms}) begin
                        n_blink  = 1'b0;
                        n_toggle = i_time;
                        n_start  = i_time;
                        status   = ST_COOLDOWN;
                        n_phase  = PH_COOLDOWN;
                    end
                end
            end
            PH_COOLDOWN: begin
                if (i_req) begin
                    l3      = 1'b1;
                    status  = ST_RUNNING;
                    n_phase = PH_RUNNING;
                end else begin
                    n_blink  = blink_next;
                    n_toggle = toggle_next;
                    l1       = 1'b1;
                    l2       = blink_next;
                    l3       = 1'b1;
                    status   = ST_COOLDOWN;
                    if (phase_elapsed >= {{(TimeW-DurW){1'b0}}, i_cfg.cooldown_ms}) begin
                        l1      = 1'b0;
                        l2      = 1'b0;
                        l3      = 1'b0;
                        status  = ST_STOPPED;
                        n_phase = PH_STOPPED;
                    end
                end
            end
            default: begin
                // unused code: fall back to idle, lamps off
                status  = ST_IDLE;
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_start  <= '0;
            r_toggle <= '0;
            r_blink  <= 1'b0;
        end else if (i_upd) begin
            r_phase  <= n_phase;
            r_start  <= n_start;
            r_toggle <= n_toggle;
            r_blink  <= n_blink;
        end
    end

    assign o_res.lamp_one    = l1;
    assign o_res.lamp_two    = l2;
    assign o_res.lamp_three  = l3;
    assign o_res.status_code = status;
    assign o_res.is_running  = (status == ST_RUNNING);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_phase == PH_IDLE) && !r_blink)
        else $error("phase not idle after reset");

    a_hold_without_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_upd |=> $stable(r_phase) && $stable(r_start) && $stable(r_toggle) && $stable(r_blink))
        else $error("sequencer state moved without a transfer");

    a_crank_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd && (r_phase == PH_STARTUP) && (n_phase == PH_CRANK)
        |=> !r_blink && (r_toggle == $past(i_time)) && (r_start == $past(i_time)))
        else $error("crank entry did not reset blink timer");

    a_crank_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd && ((r_phase == PH_CRANK) || (r_phase == PH_STARTUP)) && !i_req
        |=> r_phase == PH_STOPPED)
        else $error("dropped request during startup did not stop");

endmodule

### bench/sequencer_checker.sv
// Checker for the start/stop sequencer: predicts each result and compares it on the output stream.
`timescale 1ns / 1ps

module sequencer_checker import gsss_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [InDataW-1:0]  i_in_data,    // [31:0] time_ms, [32] request_run
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [OutDataW-1:0] i_out_data,   // [0] lamp_one, [1] lamp_two, [2] lamp_three,
                                              // [5:3] status_code, [6] is_running
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [DurW-1:0]     i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);

    logic [DurW-1:0]    dur_startup;
    logic [DurW-1:0]    dur_crank;
    logic [DurW-1:0]    dur_shutdown;
    logic [DurW-1:0]    dur_cooldown;
    logic [DurW-1:0]    dur_blink;

    logic [StatusW-1:0] seq_phase;
    logic [TimeW-1:0]   phase_t0;
    logic [TimeW-1:0]   toggle_t;
    logic               blink_on;

    t_result            lamps_expected[$];
    int                 mismatch_count = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic void step_blink(input logic [TimeW-1:0] now);
        logic [TimeW-1:0] since;
        since = now - toggle_t;
        if (since >= {16'd0, dur_blink}) begin
            blink_on = ~blink_on;
            toggle_t = now;
        end
    endfunction

    function automatic t_result predict_lamps(input logic [TimeW-1:0] now, input logic req);
        t_result          r;
        logic [TimeW-1:0] spent;
        r = '0;
        spent = now - phase_t0;
        case (seq_phase)
            ST_IDLE, ST_STOPPED: begin
                r.status_code = seq_phase;
                if (req) begin
                    r.lamp_one    = 1'b1;
                    r.status_code = ST_STARTUP;
                    phase_t0      = now;
                    seq_phase     = ST_STARTUP;
                end
            end
            ST_STARTUP: begin
                if (!req) begin
                    r.status_code = ST_STOPPED;
                    seq_phase     = ST_STOPPED;
                end else begin
                    r.lamp_one    = 1'b1;
                    r.status_code = ST_STARTUP;
                    if (spent >= {16'd0, dur_startup}) begin
                        blink_on      = 1'b0;
                        toggle_t      = now;
                        phase_t0      = now;
                        r.status_code = ST_CRANK;
                        seq_phase     = ST_CRANK;
                    end
                end
            end
            ST_CRANK: begin
                if (!req) begin
                    r.status_code = ST_STOPPED;
                    seq_phase     = ST_STOPPED;
                end else begin
                    step_blink(now);
                    r.lamp_one    = 1'b1;
                    r.lamp_two    = blink_on;
                    r.status_code = ST_CRANK;
                    if (spent >= {16'd0, dur_crank}) begin
                        r.lamp_one    = 1'b0;
                        r.lamp_two    = 1'b0;
                        r.lamp_three  = 1'b1;
                        r.status_code = ST_RUNNING;
                        phase_t0      = now;
                        seq_phase     = ST_RUNNING;
                    end
                end
            end
            ST_RUNNING: begin
                r.lamp_three  = 1'b1;
                r.status_code = ST_RUNNING;
                if (!req) begin
                    r.lamp_one    = 1'b1;
                    r.status_code = ST_SHUTDOWN;
                    phase_t0      = now;
                    seq_phase     = ST_SHUTDOWN;
                end
            end
            ST_SHUTDOWN: begin
                r.lamp_three = 1'b1;
                if (req) begin
                    // back to running, start time kept
                    r.status_code = ST_RUNNING;
                    seq_phase     = ST_RUNNING;
                end else begin
                    r.lamp_one    = 1'b1;
                    r.status_code = ST_SHUTDOWN;
                    if (spent >= {16'd0, dur_shutdown}) begin
                        blink_on      = 1'b0;
                        toggle_t      = now;
                        phase_t0      = now;
                        r.status_code = ST_COOLDOWN;
                        seq_phase     = ST_COOLDOWN;
                    end
                end
            end
            ST_COOLDOWN: begin
                if (req) begin
                    r.lamp_three  = 1'b1;
                    r.status_code = ST_RUNNING;
                    seq_phase     = ST_RUNNING;
                end else begin
                    step_blink(now);
                    r.lamp_one    = 1'b1;
                    r.lamp_two    = blink_on;
                    r.lamp_three  = 1'b1;
                    r.status_code = ST_COOLDOWN;
                    if (spent >= {16'd0, dur_cooldown}) begin
                        r.lamp_one    = 1'b0;
                        r.lamp_two    = 1'b0;
                        r.lamp_three  = 1'b0;
                        r.status_code = ST_STOPPED;
                        seq_phase     = ST_STOPPED;
                    end
                end
            end
            default: begin
                seq_phase     = ST_IDLE;
                r.status_code = ST_IDLE;
            end
        endcase
        r.is_running = (r.status_code == ST_RUNNING);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            dur_startup  = RST_STARTUP_HOLD;
            dur_crank    = RST_CRANK;
            dur_shutdown = RST_SHUTDOWN_HOLD;
            dur_cooldown = RST_COOLDOWN;
            dur_blink    = RST_BLINK_PERIOD;
            seq_phase    = ST_IDLE;
            phase_t0     = '0;
            toggle_t     = '0;
            blink_on     = 1'b0;
            lamps_expected.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STARTUP_HOLD:  dur_startup  = i_cfg_data;
                    CFG_CRANK:         dur_crank    = i_cfg_data;
                    CFG_SHUTDOWN_HOLD: dur_shutdown = i_cfg_data;
                    CFG_COOLDOWN:      dur_cooldown = i_cfg_data;
                    CFG_BLINK_PERIOD:  dur_blink    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                lamps_expected.push_back(predict_lamps(i_in_data[31:0], i_in_data[32]));
            if (i_out_valid && i_out_ready) begin
                got = t_result'(i_out_data[6:0]);
                if (lamps_expected.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result transfer with nothing expected, data %h",
                                 $realtime, i_out_data);
                end else begin
                    want = lamps_expected.pop_front();
                    if (got.lamp_one !== want.lamp_one || got.lamp_two !== want.lamp_two ||
                        got.lamp_three !== want.lamp_three ||
                        got.status_code !== want.status_code ||
                        got.is_running !== want.is_running || i_out_data[7] !== 1'b0) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $write("%0t: mismatch, expected lamps %b%b%b status %0d run %b,",
                                   $realtime, want.lamp_one, want.lamp_two, want.lamp_three,
                                   want.status_code, want.is_running);
                            $display(" got lamps %b%b%b status %0d run %b (data %h)",
                                     got.lamp_one, got.lamp_two, got.lamp_three,
                                     got.status_code, got.is_running, i_out_data);
                        end
                    end
                end
            end
        end
        o_pending <= lamps_expected.size();
        o_errors  <= mismatch_count;
    end

endmodule

### bench/generator_start_stop_sequencer_test.sv
// Testbench top for the start/stop sequencer: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps

module generator_start_stop_sequencer_test;
    import gsss_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic                cfg_we   = 1'b0;
    logic [CfgIdxW-1:0]  cfg_idx  = CFG_STARTUP_HOLD;
    logic [DurW-1:0]     cfg_data = '0;

    int                  errors;
    int                  pending;
    int                  cycles    = 0;
    int                  rx_hold   = 0;
    logic                idle_mode = 1'b1;
    logic [TimeW-1:0]    clock_ms  = '0;
    logic                want_run  = 1'b0;
    int                  run_left  = 0;

    always #1 clk = ~clk;

    generator_start_stop_sequencer u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    sequencer_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (s_tvalid),
        .i_in_ready  (s_tready),
        .i_in_data   (s_tdata),
        .i_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_out_data  (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_mode || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (rx_hold != 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else begin
            m_tready <= 1'b1;
            if (idle_mode && $urandom_range(0, 3) == 0)
                rx_hold <= pick_gap();
        end
    end

    task automatic send_update(input logic [TimeW-1:0] t, input logic req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, req, t};
        do @(posedge clk); while (!s_tready);
    endtask

    // stop sending and let every expected result come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_durations(input logic [DurW-1:0] d [5]);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_STARTUP_HOLD;
        cfg_data <= d[0];
        @(posedge clk);
        cfg_idx  <= CFG_CRANK;
        cfg_data <= d[1];
        @(posedge clk);
        cfg_idx  <= CFG_SHUTDOWN_HOLD;
        cfg_data <= d[2];
        @(posedge clk);
        cfg_idx  <= CFG_COOLDOWN;
        cfg_data <= d[3];
        @(posedge clk);
        cfg_idx  <= CFG_BLINK_PERIOD;
        cfg_data <= d[4];
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // run/stop requests held for random stretches, with odd glitches and time jumps
    task automatic run_updates(input int count, input int unsigned span);
        int unsigned r;
        logic        glitch;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            glitch = 1'b0;
            if (run_left == 0) begin
                want_run = ~want_run;
                run_left = $urandom_range(1, 16);
            end
            run_left--;
            if (r < 4) begin
                clock_ms = $urandom;
            end else begin
                clock_ms = clock_ms + $urandom_range(0, span);
                glitch   = (r < 9);
            end
            send_update(clock_ms, want_run ^ glitch);
        end
    endtask

    initial begin
        logic [TimeW-1:0] base;
        logic [DurW-1:0]  durs [5];
        int unsigned      longest;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk with reset durations, crossing the timestamp wrap
        send_update(32'h0000_0000, 1'b0);
        send_update(32'hFFFF_FFFF, 1'b0);
        base = 32'hFFFF_FF00;
        send_update(base, 1'b1);
        send_update(base + 999, 1'b1);
        base = base + 1000;
        send_update(base, 1'b1);
        send_update(base + 199, 1'b1);
        send_update(base + 200, 1'b1);
        send_update(base + 400, 1'b1);
        send_update(base + 2999, 1'b1);
        base = base + 3000;
        send_update(base, 1'b1);
        send_update(base + 10, 1'b0);
        send_update(base + 20, 1'b1);
        send_update(base + 30, 1'b0);
        send_update(base + 1030, 1'b0);
        send_update(base + 1230, 1'b0);
        send_update(base + 1300, 1'b1);
        send_update(base + 1310, 1'b0);
        send_update(base + 2310, 1'b0);
        send_update(base + 5309, 1'b0);
        send_update(base + 5310, 1'b0);
        send_update(base + 5311, 1'b0);
        send_update(base + 5312, 1'b1);
        send_update(base + 5313, 1'b0);
        send_update(base + 5314, 1'b1);
        send_update(base + 6314, 1'b1);
        send_update(base + 6315, 1'b0);
        clock_ms = base + 6400;
        run_updates(90, 1200);

        for (int p = 0; p < 6; p++) begin
            drain();
            for (int k = 0; k < 5; k++) begin
                case (p)
                    0:       durs[k] = '0;
                    1:       durs[k] = '1;
                    2, 4:    durs[k] = DurW'($urandom_range(0, 40));
                    default: durs[k] = DurW'($urandom_range(0, 65535));
                endcase
            end
            longest = 0;
            for (int k = 0; k < 5; k++)
                if (32'(durs[k]) > longest)
                    longest = 32'(durs[k]);
            idle_mode = (p != 0);
            load_durations(durs);
            run_updates(90, longest / 3 + 2);
        end

        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
design/gsss_pkg.sv
design/gsss_cfg.sv
design/gsss_core.sv
design/generator_start_stop_sequencer.sv
bench/sequencer_checker.sv
bench/generator_start_stop_sequencer_test.sv
